### rtl/core/slx_pkg.sv
// Shared types and constants for the SM83-style load and ALU execute core.
package slx_pkg;

   // Operation classes assigned by the front decoder.
   typedef logic [2:0] op_class_type;
   localparam op_class_type CLS_UNSUP = 3'd0;
   localparam op_class_type CLS_NOP   = 3'd1;
   localparam op_class_type CLS_MISC  = 3'd2;
   localparam op_class_type CLS_LOAD  = 3'd3;
   localparam op_class_type CLS_HALT  = 3'd4;
   localparam op_class_type CLS_ALU   = 3'd5;

   // Block 0 accumulator operations, selected by opcode bits 5:3.
   localparam logic [2:0] MISC_RLCA = 3'd0;
   localparam logic [2:0] MISC_RRCA = 3'd1;
   localparam logic [2:0] MISC_RLA  = 3'd2;
   localparam logic [2:0] MISC_RRA  = 3'd3;
   localparam logic [2:0] MISC_DAA  = 3'd4;
   localparam logic [2:0] MISC_CPL  = 3'd5;
   localparam logic [2:0] MISC_SCF  = 3'd6;
   localparam logic [2:0] MISC_CCF  = 3'd7;

   // Block 2 ALU operations, selected by opcode bits 5:3.
   localparam logic [2:0] ALU_ADD = 3'd0;
   localparam logic [2:0] ALU_ADC = 3'd1;
   localparam logic [2:0] ALU_SUB = 3'd2;
   localparam logic [2:0] ALU_SBC = 3'd3;
   localparam logic [2:0] ALU_AND = 3'd4;
   localparam logic [2:0] ALU_XOR = 3'd5;
   localparam logic [2:0] ALU_OR  = 3'd6;
   localparam logic [2:0] ALU_CP  = 3'd7;

   // Register file indexes; index 6 names the byte at HL.
   localparam logic [2:0] IDX_H   = 3'd4;
   localparam logic [2:0] IDX_L   = 3'd5;
   localparam logic [2:0] IDX_MEM = 3'd6;
   localparam logic [2:0] IDX_A   = 3'd7;

   // Flag bit positions.
   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   // Decoded operation carried from the front to the back through the queue.
   typedef struct packed {
      op_class_type op_class;
      logic [2:0]   op_y;
      logic [2:0]   op_z;
      logic [7:0]   mem_data;
   } uop_type;

endpackage

### rtl/core/slx_decode.sv
// Front end: accepts opcode words and classifies them into decoded operations.
module slx_decode
   import slx_pkg::*;
(
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_opcode,
   input  logic [7:0] req_hl_read_data,
   input  logic       queue_full,
   output logic       push_valid,
   output uop_type    push_data
);

   localparam logic [1:0] BLK_MISC = 2'd0;
   localparam logic [1:0] BLK_LOAD = 2'd1;
   localparam logic [1:0] BLK_ALU  = 2'd2;
   localparam logic [1:0] BLK_HIGH = 2'd3;

   logic [2:0] op_y;
   logic [2:0] op_z;

   assign op_y = req_opcode[5:3];
   assign op_z = req_opcode[2:0];

   // The front takes a word whenever the queue has room.
   assign req_stall  = queue_full;
   assign push_valid = req_valid;

   // Classify the opcode by block and operand fields.
   always_comb begin
      push_data.op_y     = op_y;
      push_data.op_z     = op_z;
      push_data.mem_data = req_hl_read_data;
      push_data.op_class = CLS_UNSUP;
      unique case (req_opcode[7:6])
         BLK_MISC: begin
            if (req_opcode == 8'h00) begin
               push_data.op_class = CLS_NOP;
            end else if (op_z == 3'd7 && op_y != MISC_DAA) begin
               push_data.op_class = CLS_MISC;
            end else begin
               push_data.op_class = CLS_UNSUP;
            end
         end
         BLK_LOAD: begin
            if (op_y == IDX_MEM && op_z == IDX_MEM) begin
               push_data.op_class = CLS_HALT;
            end else begin
               push_data.op_class = CLS_LOAD;
            end
         end
         BLK_ALU: push_data.op_class = CLS_ALU;
         BLK_HIGH: push_data.op_class = CLS_UNSUP;
      endcase
   end

endmodule

### rtl/core/slx_queue.sv
// Short queue of decoded operations between the front and the back.
module slx_queue
   import slx_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  uop_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output uop_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   uop_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               push_fire;
   logic               pop_fire;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign push_fire = push_valid && !full;
   assign pop_fire  = pop && pop_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push_fire, pop_fire})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/slx_execute.sv
// Back end: executes decoded operations against the register file and flags.
module slx_execute
   import slx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        uop_valid,
   input  uop_type     uop,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_acc_value,
   output logic [3:0]  rsp_flag_bits,
   output logic        rsp_mem_write,
   output logic [15:0] rsp_mem_address,
   output logic [7:0]  rsp_mem_write_data,
   output logic [15:0] rsp_program_count,
   output logic        rsp_halt_seen,
   output logic        rsp_unsupported
);

   // Architectural state.
   logic [7:0]  rf_ff [8];
   logic [3:0]  flag_ff;
   logic [3:0]  flag_in;
   logic [15:0] pc_ff;
   logic [15:0] pc_in;
   logic [31:0] icount_ff;

   // Result register.
   logic        rsp_valid_ff;
   logic [7:0]  acc_out_ff;
   logic [3:0]  flag_out_ff;
   logic        mem_write_ff;
   logic        mem_write_in;
   logic [15:0] mem_address_ff;
   logic [7:0]  mem_data_ff;
   logic [7:0]  mem_data_in;
   logic [15:0] pc_out_ff;
   logic        halt_ff;
   logic        halt_in;
   logic        unsup_ff;
   logic        unsup_in;

   logic [7:0]  acc;
   logic [7:0]  acc_in;
   logic        carry;
   logic [7:0]  src_val;
   logic        rf_write;
   logic        step;
   logic        fire;

   logic        alu_cin;
   logic [8:0]  sum9;
   logic [4:0]  half_sum;
   logic [8:0]  diff9;
   logic [4:0]  half_diff;
   logic [7:0]  alu_res;
   logic        alu_n;
   logic        alu_h;
   logic        alu_c;

   assign acc     = rf_ff[IDX_A];
   assign carry   = flag_ff[FLAG_C];
   assign src_val = (uop.op_z == IDX_MEM) ? uop.mem_data : rf_ff[uop.op_z];

   // Take the next operation when the result register is free or draining.
   assign fire = uop_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop  = fire;

   // Eight-bit ALU with half and full carry.
   always_comb begin
      alu_cin   = carry && (uop.op_y == ALU_ADC || uop.op_y == ALU_SBC);
      sum9      = {1'b0, acc} + {1'b0, src_val} + {8'd0, alu_cin};
      half_sum  = {1'b0, acc[3:0]} + {1'b0, src_val[3:0]} + {4'd0, alu_cin};
      diff9     = {1'b0, acc} - {1'b0, src_val} - {8'd0, alu_cin};
      half_diff = {1'b0, acc[3:0]} - {1'b0, src_val[3:0]} - {4'd0, alu_cin};
      alu_res   = sum9[7:0];
      alu_n     = 1'b0;
      alu_h     = 1'b0;
      alu_c     = 1'b0;
      unique case (uop.op_y)
         ALU_ADD, ALU_ADC: begin
            alu_res = sum9[7:0];
            alu_h   = half_sum[4];
            alu_c   = sum9[8];
         end
         ALU_SUB, ALU_SBC, ALU_CP: begin
            alu_res = diff9[7:0];
            alu_n   = 1'b1;
            alu_h   = half_diff[4];
            alu_c   = diff9[8];
         end
         ALU_AND: begin
            alu_res = acc & src_val;
            alu_h   = 1'b1;
         end
         ALU_XOR: alu_res = acc ^ src_val;
         ALU_OR:  alu_res = acc | src_val;
      endcase
   end

   // Next accumulator, flags and memory write for each operation class.
   always_comb begin
      acc_in       = acc;
      flag_in      = flag_ff;
      rf_write     = 1'b0;
      mem_write_in = 1'b0;
      mem_data_in  = 8'd0;
      halt_in      = 1'b0;
      unsup_in     = 1'b0;
      step         = 1'b1;
      unique case (uop.op_class)
         CLS_NOP: begin
         end
         CLS_MISC: begin
            unique case (uop.op_y)
               MISC_RLCA: begin
                  acc_in  = {acc[6:0], acc[7]};
                  flag_in = {3'b000, acc[7]};
               end
               MISC_RRCA: begin
                  acc_in  = {acc[0], acc[7:1]};
                  flag_in = {3'b000, acc[0]};
               end
               MISC_RLA: begin
                  acc_in  = {acc[6:0], carry};
                  flag_in = {3'b000, acc[7]};
               end
               MISC_RRA: begin
                  acc_in  = {carry, acc[7:1]};
                  flag_in = {3'b000, acc[0]};
               end
               MISC_DAA: begin
                  unsup_in = 1'b1;
                  step     = 1'b0;
               end
               MISC_CPL: begin
                  acc_in          = ~acc;
                  flag_in[FLAG_N] = 1'b1;
                  flag_in[FLAG_H] = 1'b1;
               end
               MISC_SCF: flag_in = {flag_ff[FLAG_Z], 3'b001};
               MISC_CCF: flag_in = {flag_ff[FLAG_Z], 2'b00, ~carry};
            endcase
         end
         CLS_LOAD: begin
            if (uop.op_y == IDX_MEM) begin
               mem_write_in = 1'b1;
               mem_data_in  = src_val;
            end else begin
               rf_write = 1'b1;
               if (uop.op_y == IDX_A) begin
                  acc_in = src_val;
               end
            end
         end
         CLS_HALT: halt_in = 1'b1;
         CLS_ALU: begin
            if (uop.op_y != ALU_CP) begin
               acc_in = alu_res;
            end
            flag_in = {(alu_res == 8'd0), alu_n, alu_h, alu_c};
         end
         default: begin
            unsup_in = 1'b1;
            step     = 1'b0;
         end
      endcase
      pc_in = pc_ff + {15'd0, step};
   end

   // State update and result capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            rf_ff[i] <= 8'd0;
         end
         flag_ff      <= 4'd0;
         pc_ff        <= 16'd0;
         icount_ff    <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            rsp_valid_ff <= 1'b1;
            flag_ff      <= flag_in;
            pc_ff        <= pc_in;
            icount_ff    <= icount_ff + {31'd0, step};
            if (rf_write) begin
               rf_ff[uop.op_y] <= src_val;
            end else begin
               rf_ff[IDX_A] <= acc_in;
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload; held while the consumer stalls.
   always_ff @(posedge clock) begin
      if (fire) begin
         acc_out_ff     <= acc_in;
         flag_out_ff    <= flag_in;
         mem_write_ff   <= mem_write_in;
         mem_address_ff <= {rf_ff[IDX_H], rf_ff[IDX_L]};
         mem_data_ff    <= mem_data_in;
         pc_out_ff      <= pc_in;
         halt_ff        <= halt_in;
         unsup_ff       <= unsup_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_acc_value      = acc_out_ff;
   assign rsp_flag_bits      = flag_out_ff;
   assign rsp_mem_write      = mem_write_ff;
   assign rsp_mem_address    = mem_address_ff;
   assign rsp_mem_write_data = mem_data_ff;
   assign rsp_program_count  = pc_out_ff;
   assign rsp_halt_seen      = halt_ff;
   assign rsp_unsupported    = unsup_ff;

endmodule

### rtl/core/sm83_alu_load_execute_core.sv
// Top level of the SM83-style load and ALU execute core.
//
//   Channel   Direction   Handshake            Payload
//   req_      in          req_valid/req_stall  opcode, hl_read_data
//   rsp_      out         rsp_valid/rsp_stall  acc_value, flag_bits, mem_*, program_count,
//                                              halt_seen, unsupported
//
// One word is accepted and one result retired per cycle while rsp_stall is low. A word
// accepted is written into a queue entry, then executed into the execute stage's result
// register, where it waits until taken. The execute stage reads and writes the register
// file as it takes each operation, which sets that rate.
// Reset clears registers, flags, program counter, instruction count and the queue.
// A stalled result holds the execute stage; the front keeps taking words until the
// queue of QUEUE_DEPTH entries is full, then raises req_stall.
module sm83_alu_load_execute_core
   import slx_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_opcode,
   input  logic [7:0]  req_hl_read_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_acc_value,
   output logic [3:0]  rsp_flag_bits,
   output logic        rsp_mem_write,
   output logic [15:0] rsp_mem_address,
   output logic [7:0]  rsp_mem_write_data,
   output logic [15:0] rsp_program_count,
   output logic        rsp_halt_seen,
   output logic        rsp_unsupported
);

   logic    queue_full;
   logic    push_valid;
   uop_type push_data;
   logic    pop;
   logic    pop_valid;
   uop_type pop_data;

   // Front: accept and classify.
   slx_decode u_decode (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_hl_read_data (req_hl_read_data),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_data        (push_data)
   );

   // Queue between front and back.
   slx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   // Back: execute and deliver results.
   slx_execute u_execute (
      .clock              (clock),
      .reset              (reset),
      .uop_valid          (pop_valid),
      .uop                (pop_data),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_acc_value      (rsp_acc_value),
      .rsp_flag_bits      (rsp_flag_bits),
      .rsp_mem_write      (rsp_mem_write),
      .rsp_mem_address    (rsp_mem_address),
      .rsp_mem_write_data (rsp_mem_write_data),
      .rsp_program_count  (rsp_program_count),
      .rsp_halt_seen      (rsp_halt_seen),
      .rsp_unsupported    (rsp_unsupported)
   );

endmodule

### tb/sm83_alu_load_execute_core_tb.sv
// Self-checking testbench for the SM83-style load and ALU execute core.
module sm83_alu_load_execute_core_tb;
   import slx_pkg::*;

   // Opcode blocks, selected by opcode bits 7:6.
   localparam logic [1:0] BLK_MISC = 2'd0;
   localparam logic [1:0] BLK_LOAD = 2'd1;
   localparam logic [1:0] BLK_ALU  = 2'd2;

   // Block 0 accumulator operations all have this low field.
   localparam logic [2:0] MISC_Z_ACC = 3'd7;

   // Named opcodes used in the directed cases.
   localparam logic [7:0] OPC_NOP      = 8'h00;
   localparam logic [7:0] OPC_STOP     = 8'h10;
   localparam logic [7:0] OPC_LD_A_IMM = 8'h3E;
   localparam logic [7:0] OPC_RST38    = 8'hFF;

   // Register index of B, used by the register-to-register directed case.
   localparam logic [2:0] IDX_B = 3'd0;

   localparam int CLOCK_HALF     = 10;
   localparam int RESET_CYCLES   = 8;
   localparam int HOLD_CYCLES    = 64;
   localparam int DRAIN_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT = 2000;

   // Expected contents of one result word.
   typedef struct {
      logic [7:0]  acc;
      logic [3:0]  flags;
      logic        mem_write;
      logic [15:0] addr;
      logic [7:0]  wdata;
      logic [15:0] pc;
      logic        halt;
      logic        unsupported;
   } exec_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_opcode = 8'h00;
   logic [7:0]  req_hl_read_data = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_acc_value;
   logic [3:0]  rsp_flag_bits;
   logic        rsp_mem_write;
   logic [15:0] rsp_mem_address;
   logic [7:0]  rsp_mem_write_data;
   logic [15:0] rsp_program_count;
   logic        rsp_halt_seen;
   logic        rsp_unsupported;

   // Shadow copy of the architectural state.
   logic [7:0]  shadow_regs [0:7];
   logic [3:0]  shadow_flags = 4'h0;
   logic [15:0] shadow_pc = 16'h0000;
   logic [31:0] shadow_icount = 32'h0;

   exec_result_type pending_results[$];

   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   logic hold_request = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int mismatch_count = 0;
   int words_sent = 0;
   int words_executed = 0;
   int results_checked = 0;

   sm83_alu_load_execute_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_hl_read_data   (req_hl_read_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_acc_value      (rsp_acc_value),
      .rsp_flag_bits      (rsp_flag_bits),
      .rsp_mem_write      (rsp_mem_write),
      .rsp_mem_address    (rsp_mem_address),
      .rsp_mem_write_data (rsp_mem_write_data),
      .rsp_program_count  (rsp_program_count),
      .rsp_halt_seen      (rsp_halt_seen),
      .rsp_unsupported    (rsp_unsupported)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < 8; i++) shadow_regs[i] = 8'h00;
   end

   function automatic logic [7:0] make_opcode(logic [1:0] blk, logic [2:0] y, logic [2:0] z);
      return {blk, y, z};
   endfunction

   // Executes one opcode on the shadow state and queues the result word it must produce.
   task automatic retire_opcode(input logic [7:0] opcode, input logic [7:0] mem_byte,
                                output bit executed);
      exec_result_type r;
      logic [1:0] blk;
      logic [2:0] y, z;
      logic [7:0] acc, operand, res;
      logic [3:0] flg;
      logic [8:0] wide;
      logic [4:0] nib;
      logic cin, c, ok;
      blk = opcode[7:6];
      y = opcode[5:3];
      z = opcode[2:0];
      acc = shadow_regs[IDX_A];
      flg = shadow_flags;
      cin = flg[FLAG_C];
      ok = 1'b1;
      operand = (z == IDX_MEM) ? mem_byte : shadow_regs[z];
      r.addr = {shadow_regs[IDX_H], shadow_regs[IDX_L]};
      r.mem_write = 1'b0;
      r.wdata = 8'h00;
      r.halt = 1'b0;
      case (blk)
         BLK_MISC: begin
            if (opcode == OPC_NOP) begin
               ok = 1'b1;
            end else if (z == MISC_Z_ACC) begin
               case (y)
                  MISC_RLCA: begin
                     flg = 4'h0;
                     flg[FLAG_C] = acc[7];
                     acc = {acc[6:0], acc[7]};
                  end
                  MISC_RRCA: begin
                     flg = 4'h0;
                     flg[FLAG_C] = acc[0];
                     acc = {acc[0], acc[7:1]};
                  end
                  MISC_RLA: begin
                     flg = 4'h0;
                     flg[FLAG_C] = acc[7];
                     acc = {acc[6:0], cin};
                  end
                  MISC_RRA: begin
                     flg = 4'h0;
                     flg[FLAG_C] = acc[0];
                     acc = {cin, acc[7:1]};
                  end
                  MISC_DAA: ok = 1'b0;
                  MISC_CPL: begin
                     acc = ~acc;
                     flg[FLAG_N] = 1'b1;
                     flg[FLAG_H] = 1'b1;
                  end
                  MISC_SCF: begin
                     flg[FLAG_N] = 1'b0;
                     flg[FLAG_H] = 1'b0;
                     flg[FLAG_C] = 1'b1;
                  end
                  default: begin
                     flg[FLAG_N] = 1'b0;
                     flg[FLAG_H] = 1'b0;
                     flg[FLAG_C] = ~flg[FLAG_C];
                  end
               endcase
               if (ok) begin
                  shadow_regs[IDX_A] = acc;
                  shadow_flags = flg;
               end
            end else begin
               ok = 1'b0;
            end
         end
         BLK_LOAD: begin
            // Both operands at HL encode halt; a destination at HL goes out as a store.
            if (y == IDX_MEM && z == IDX_MEM) begin
               r.halt = 1'b1;
            end else if (y == IDX_MEM) begin
               r.mem_write = 1'b1;
               r.wdata = operand;
            end else begin
               shadow_regs[y] = operand;
            end
         end
         BLK_ALU: begin
            flg = 4'h0;
            res = acc;
            case (y)
               ALU_ADD, ALU_ADC: begin
                  c = (y == ALU_ADC) ? cin : 1'b0;
                  wide = {1'b0, acc} + {1'b0, operand} + {8'h00, c};
                  nib = {1'b0, acc[3:0]} + {1'b0, operand[3:0]} + {4'h0, c};
                  flg[FLAG_H] = nib[4];
                  flg[FLAG_C] = wide[8];
                  res = wide[7:0];
               end
               ALU_SUB, ALU_SBC, ALU_CP: begin
                  // Borrows show up as the top bit of the widened differences.
                  c = (y == ALU_SBC) ? cin : 1'b0;
                  wide = {1'b0, acc} - {1'b0, operand} - {8'h00, c};
                  nib = {1'b0, acc[3:0]} - {1'b0, operand[3:0]} - {4'h0, c};
                  flg[FLAG_N] = 1'b1;
                  flg[FLAG_H] = nib[4];
                  flg[FLAG_C] = wide[8];
                  res = wide[7:0];
               end
               ALU_AND: begin
                  res = acc & operand;
                  flg[FLAG_H] = 1'b1;
               end
               ALU_XOR: res = acc ^ operand;
               default: res = acc | operand;
            endcase
            flg[FLAG_Z] = (res == 8'h00);
            shadow_flags = flg;
            if (y != ALU_CP) shadow_regs[IDX_A] = res;
         end
         default: ok = 1'b0;
      endcase
      if (ok) begin
         shadow_pc = shadow_pc + 16'd1;
         shadow_icount = shadow_icount + 32'd1;
      end
      r.acc = shadow_regs[IDX_A];
      r.flags = shadow_flags;
      r.pc = shadow_pc;
      r.unsupported = ~ok;
      pending_results.push_back(r);
      executed = ok;
   endtask

   // Offers one word, with an optional idle gap first, and waits until it is taken.
   task automatic send_word(input logic [7:0] opcode, input logic [7:0] mem_byte,
                            output bit executed);
      int gap;
      if ($urandom_range(99) < sender_idle_pct) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         req_opcode <= 8'($urandom);
         req_hl_read_data <= 8'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= opcode;
      req_hl_read_data <= mem_byte;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      retire_opcode(opcode, mem_byte, executed);
      words_sent++;
      if (executed) words_executed++;
   endtask

   // Random word, weighted toward ALU and load opcodes so register contents keep moving.
   task automatic send_random_word(output bit executed);
      logic [7:0] opcode, mem_byte;
      int pick;
      pick = $urandom_range(99);
      if (pick < 40)
         opcode = make_opcode(BLK_ALU, 3'($urandom), 3'($urandom));
      else if (pick < 70)
         opcode = make_opcode(BLK_LOAD, 3'($urandom), 3'($urandom));
      else if (pick < 82)
         opcode = make_opcode(BLK_MISC, 3'($urandom), MISC_Z_ACC);
      else if (pick < 85)
         opcode = OPC_NOP;
      else
         opcode = 8'($urandom);
      pick = $urandom_range(7);
      if (pick == 0)
         mem_byte = 8'h00;
      else if (pick == 1)
         mem_byte = 8'hFF;
      else
         mem_byte = 8'($urandom);
      send_word(opcode, mem_byte, executed);
   endtask

   // Extremes, every operation and the special opcodes, in an order that chains state.
   task automatic test_directed_opcodes();
      bit executed;
      send_word(OPC_NOP, 8'h00, executed);
      send_word(OPC_LD_A_IMM, 8'h5A, executed);
      send_word(make_opcode(BLK_LOAD, IDX_A, IDX_MEM), 8'hFF, executed);
      send_word(make_opcode(BLK_LOAD, IDX_H, IDX_MEM), 8'h80, executed);
      send_word(make_opcode(BLK_LOAD, IDX_L, IDX_MEM), 8'h01, executed);
      send_word(make_opcode(BLK_LOAD, IDX_B, IDX_A), 8'h00, executed);
      send_word(make_opcode(BLK_LOAD, IDX_MEM, IDX_B), 8'h00, executed);
      send_word(make_opcode(BLK_LOAD, IDX_MEM, IDX_MEM), 8'hFF, executed);
      send_word(make_opcode(BLK_ALU, ALU_ADD, IDX_MEM), 8'hFF, executed);
      send_word(make_opcode(BLK_ALU, ALU_ADC, IDX_MEM), 8'h01, executed);
      send_word(make_opcode(BLK_ALU, ALU_SUB, IDX_MEM), 8'h00, executed);
      send_word(make_opcode(BLK_ALU, ALU_SBC, IDX_MEM), 8'hFF, executed);
      send_word(make_opcode(BLK_ALU, ALU_AND, IDX_MEM), 8'h0F, executed);
      send_word(make_opcode(BLK_ALU, ALU_XOR, IDX_MEM), 8'hF0, executed);
      send_word(make_opcode(BLK_ALU, ALU_OR, IDX_B), 8'h00, executed);
      send_word(make_opcode(BLK_ALU, ALU_CP, IDX_MEM), 8'hFF, executed);
      send_word(make_opcode(BLK_MISC, MISC_RLCA, MISC_Z_ACC), 8'h00, executed);
      send_word(make_opcode(BLK_MISC, MISC_RRCA, MISC_Z_ACC), 8'h00, executed);
      send_word(make_opcode(BLK_MISC, MISC_RLA, MISC_Z_ACC), 8'h00, executed);
      send_word(make_opcode(BLK_MISC, MISC_RRA, MISC_Z_ACC), 8'h00, executed);
      send_word(make_opcode(BLK_MISC, MISC_CPL, MISC_Z_ACC), 8'h00, executed);
      send_word(make_opcode(BLK_MISC, MISC_SCF, MISC_Z_ACC), 8'h00, executed);
      send_word(make_opcode(BLK_MISC, MISC_CCF, MISC_Z_ACC), 8'h00, executed);
      send_word(make_opcode(BLK_MISC, MISC_DAA, MISC_Z_ACC), 8'h00, executed);
      send_word(OPC_STOP, 8'h00, executed);
      send_word(OPC_RST38, 8'hFF, executed);
   endtask

   // Random opcodes until the given number of them have executed.
   task automatic test_random_programs(input int count);
      bit executed;
      int done;
      done = 0;
      while (done < count) begin
         send_random_word(executed);
         if (executed) done++;
      end
   endtask

   // The receiver holds off for a long stretch while words keep coming, filling the queue.
   task automatic test_backpressure_fill();
      bit executed;
      int saved_pct;
      saved_pct = sender_idle_pct;
      sender_idle_pct = 0;
      hold_request <= 1'b1;
      repeat (40) send_random_word(executed);
      sender_idle_pct = saved_pct;
   endtask

   // The sender goes quiet until every outstanding result has drained, then resumes.
   task automatic test_drain_pause();
      bit executed;
      repeat (20) send_random_word(executed);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) send_random_word(executed);
   endtask

   // Receiver stall: a requested long hold first, otherwise random per the idle setting.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_request) begin
         hold_request <= 1'b0;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Each result word taken is compared against the oldest expectation.
   always @(posedge clock) begin : check_results
      exec_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result word with nothing expected, acc %h flags %h pc %h",
                     $time, rsp_acc_value, rsp_flag_bits, rsp_program_count);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            compare_field("acc_value", 16'(want.acc), 16'(rsp_acc_value));
            compare_field("flag_bits", 16'(want.flags), 16'(rsp_flag_bits));
            compare_field("mem_write", 16'(want.mem_write), 16'(rsp_mem_write));
            compare_field("mem_address", want.addr, rsp_mem_address);
            compare_field("mem_write_data", 16'(want.wdata), 16'(rsp_mem_write_data));
            compare_field("program_count", want.pc, rsp_program_count);
            compare_field("halt_seen", 16'(want.halt), 16'(rsp_halt_seen));
            compare_field("unsupported", 16'(want.unsupported), 16'(rsp_unsupported));
            results_checked++;
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("sm83_alu_load_execute_core: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 33;
      receiver_idle_pct = 61;
      test_directed_opcodes();
      test_random_programs(470);

      sender_idle_pct = 61;
      receiver_idle_pct = 33;
      test_random_programs(430);
      test_backpressure_fill();
      test_drain_pause();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      test_random_programs(410);
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d opcodes (%0d executed, %0d not implemented), %0d results checked,",
               words_sent, words_executed, words_sent - words_executed, results_checked);
      $display("over directed cases, random idling on both sides, a long hold-off and a drain.");
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("sm83_alu_load_execute_core: match");
      else
         $display("sm83_alu_load_execute_core: mismatch");
      $finish;
   end

endmodule
